/* rtl/core/lzw_pkg.sv */
// Shared types and constants for the LZW decoder.
// Holds the controller state type and the command/status structs.
// No dependencies; compiled first.
package lzw_pkg;

	localparam int CODE_W   = 12;
	localparam int BYTE_W   = 8;
	localparam int LIT_CODES = 256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WALK,
		ST_UPDATE,
		ST_EMIT_FIRST,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_EMIT_EXTRA,
		ST_BAD
	} lzw_state_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic walk;
		logic update;
		logic emit_first;
		logic emit_rd;
		logic emit_wr;
		logic emit_extra;
		logic emit_bad;
	} lzw_cmd_t;

	typedef struct packed {
		logic bad;
		logic lit_target;
		logic walk_end;
		logic k_zero;
		logic idx_zero;
		logic kwk;
		logic out_free;
	} lzw_status_t;

endpackage

/* rtl/core/lzw_if.sv */
// Valid/ready channel interfaces for the LZW decoder.
// Depends on lzw_pkg for the field widths.
interface lzw_code_if
	import lzw_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code;
	logic              stream_start;

	modport source(output valid, code, stream_start, input ready);
	modport sink(input valid, code, stream_start, output ready);
endinterface

interface lzw_byte_if
	import lzw_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;
	logic              bad_code;

	modport source(output valid, out_byte, last, bad_code, input ready);
	modport sink(input valid, out_byte, last, bad_code, output ready);
endinterface

/* rtl/core/lzw_ctrl.sv */
// Controller state machine of the LZW decoder.
// Depends on lzw_pkg; drives commands to lzw_datapath from its status.
module lzw_ctrl
	import lzw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  lzw_status_t status,
	output lzw_cmd_t    cmd
);

	lzw_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.bad) state_d = ST_BAD;
				else if (status.lit_target) state_d = ST_UPDATE;
				else state_d = ST_WALK;
			end
			ST_WALK: begin
				if (status.walk_end) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_EMIT_FIRST;
			end
			ST_EMIT_FIRST: begin
				if (status.out_free) begin
					if (!status.k_zero) state_d = ST_EMIT_RD;
					else if (status.kwk) state_d = ST_EMIT_EXTRA;
					else state_d = ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (status.out_free) begin
					if (!status.idx_zero) state_d = ST_EMIT_RD;
					else if (status.kwk) state_d = ST_EMIT_EXTRA;
					else state_d = ST_IDLE;
				end
			end
			ST_EMIT_EXTRA: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			ST_BAD: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && in_valid;
		cmd.decide     = (state_q == ST_DECIDE);
		cmd.walk       = (state_q == ST_WALK);
		cmd.update     = (state_q == ST_UPDATE);
		cmd.emit_first = (state_q == ST_EMIT_FIRST) && status.out_free;
		cmd.emit_rd    = (state_q == ST_EMIT_RD);
		cmd.emit_wr    = (state_q == ST_EMIT_WR) && status.out_free;
		cmd.emit_extra = (state_q == ST_EMIT_EXTRA) && status.out_free;
		cmd.emit_bad   = (state_q == ST_BAD) && status.out_free;
	end

	// A new code is only taken with no result load in the same cycle.
	a_load_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(cmd.emit_first || cmd.emit_wr || cmd.emit_extra || cmd.emit_bad))
		else $error("code transfer overlaps a result load");
	// A rejected code leads straight to its single result.
	a_bad_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && status.bad) |=> state_q == ST_BAD)
		else $error("rejected code did not reach the error result");
	// The chain walk only ends into the dictionary update.
	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && status.walk_end) |=> state_q == ST_UPDATE)
		else $error("chain walk ended in the wrong state");

endmodule

/* rtl/core/lzw_datapath.sv */
// Datapath of the LZW decoder: dictionary memory, reverse buffer,
// decode registers and the output register. Depends on lzw_pkg.
module lzw_datapath
	import lzw_pkg::*;
#(
	parameter int DICT_SIZE = 4096,
	parameter int MAX_SEQ   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lzw_cmd_t          cmd,
	output lzw_status_t       status,
	input  logic [CODE_W-1:0] in_code,
	input  logic              in_start,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last,
	output logic              out_bad
);

	localparam int AW   = $clog2(DICT_SIZE);
	localparam int NW   = AW + 1;
	localparam int CMPW = (NW > CODE_W) ? NW : CODE_W;
	localparam int PW   = $clog2(MAX_SEQ);
	localparam int LW   = $clog2(MAX_SEQ + 1);
	localparam int DW   = CODE_W + BYTE_W;

	logic [DW-1:0]     dict_mem [DICT_SIZE];
	logic [BYTE_W-1:0] rev_mem [MAX_SEQ];

	logic [CODE_W-1:0] code_q, prev_q;
	logic [NW-1:0]     nfc_q;
	logic [LW-1:0]     prev_len_q;
	logic [BYTE_W-1:0] prev_first_q, first_q, rev_rd_q;
	logic              have_prev_q, kwk_q;
	logic [PW-1:0]     k_q, idx_q;
	logic [DW-1:0]     dict_rd_q;
	logic              out_valid_q, out_last_q, out_bad_q;
	logic [BYTE_W-1:0] out_byte_q;

	logic              defined, kwk, insert, walk_end, rd_en;
	logic [CODE_W-1:0] target, pfx, rd_src;
	logic [BYTE_W-1:0] sfx, cur_first;
	logic [CMPW-1:0]   code_c, nfc_c, rd_wide, wr_wide;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [LW-1:0]     new_len;
	logic              out_free;

	// Decode decisions for the held code.
	always_comb begin
		code_c   = CMPW'(code_q);
		nfc_c    = CMPW'(nfc_q);
		defined  = code_c < nfc_c;
		kwk      = !defined && have_prev_q && (code_c == nfc_c)
			&& (nfc_q < NW'(DICT_SIZE)) && (prev_len_q < LW'(MAX_SEQ));
		target   = kwk ? prev_q : code_q;
		pfx      = dict_rd_q[DW-1:BYTE_W];
		sfx      = dict_rd_q[BYTE_W-1:0];
		walk_end = (pfx < CODE_W'(LIT_CODES));
		rd_src   = cmd.walk ? pfx : target;
		rd_wide  = CMPW'(rd_src);
		rd_addr  = rd_wide[AW-1:0];
		rd_en    = cmd.decide || (cmd.walk && !walk_end);
		wr_wide  = CMPW'(nfc_q);
		wr_addr  = wr_wide[AW-1:0];
		insert   = have_prev_q && (nfc_q < NW'(DICT_SIZE)) && (prev_len_q < LW'(MAX_SEQ));
		cur_first = kwk_q ? prev_first_q : first_q;
		new_len  = LW'(k_q) + LW'(1) + LW'(kwk_q);
		out_free = !out_valid_q || out_ready;
	end

	// Status to the controller.
	always_comb begin
		status.bad        = !defined && !kwk;
		status.lit_target = (target < CODE_W'(LIT_CODES));
		status.walk_end   = walk_end;
		status.k_zero     = (k_q == '0);
		status.idx_zero   = (idx_q == '0);
		status.kwk        = kwk_q;
		status.out_free   = out_free;
	end

	// Dictionary memory: one read port for the chain walk, one write for insertion.
	always_ff @(posedge clk) begin
		if (rd_en) dict_rd_q <= dict_mem[rd_addr];
		if (cmd.update && insert) dict_mem[wr_addr] <= {prev_q, cur_first};
	end

	// Reverse buffer: suffixes written during the walk, read back in reverse.
	always_ff @(posedge clk) begin
		if (cmd.walk) rev_mem[k_q] <= sfx;
		if (cmd.emit_rd) rev_rd_q <= rev_mem[idx_q];
	end

	// Per-code working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) code_q <= in_code;
		if (cmd.decide) begin
			kwk_q <= kwk;
			k_q   <= '0;
			if (target < CODE_W'(LIT_CODES)) first_q <= target[BYTE_W-1:0];
		end
		if (cmd.walk) begin
			k_q <= k_q + PW'(1);
			if (walk_end) first_q <= pfx[BYTE_W-1:0];
		end
		if (cmd.emit_first) idx_q <= k_q - PW'(1);
		if (cmd.emit_wr) idx_q <= idx_q - PW'(1);
	end

	// Dictionary and history state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfc_q        <= NW'(LIT_CODES);
			prev_q       <= '0;
			prev_len_q   <= LW'(1);
			prev_first_q <= '0;
			have_prev_q  <= 1'b0;
		end else if (cmd.load && in_start) begin
			nfc_q        <= NW'(LIT_CODES);
			prev_q       <= '0;
			prev_len_q   <= LW'(1);
			prev_first_q <= '0;
			have_prev_q  <= 1'b0;
		end else if (cmd.update) begin
			if (insert) nfc_q <= nfc_q + NW'(1);
			prev_q       <= code_q;
			prev_len_q   <= new_len;
			prev_first_q <= cur_first;
			have_prev_q  <= 1'b1;
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_first || cmd.emit_wr || cmd.emit_extra || cmd.emit_bad) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_first) begin
			out_byte_q <= first_q;
			out_last_q <= (k_q == '0) && !kwk_q;
			out_bad_q  <= 1'b0;
		end else if (cmd.emit_wr) begin
			out_byte_q <= rev_rd_q;
			out_last_q <= (idx_q == '0) && !kwk_q;
			out_bad_q  <= 1'b0;
		end else if (cmd.emit_extra) begin
			out_byte_q <= prev_first_q;
			out_last_q <= 1'b1;
			out_bad_q  <= 1'b0;
		end else if (cmd.emit_bad) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			out_bad_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_bad   = out_bad_q;

	// The next free code stays between the literal count and the dictionary size.
	a_nfc_range: assert property (@(posedge clk) disable iff (!arst_n)
		nfc_q >= NW'(LIT_CODES) && nfc_q <= NW'(DICT_SIZE))
		else $error("next free code out of range");
	// Stored string lengths stay within one and the maximum.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		prev_len_q != '0 && prev_len_q <= LW'(MAX_SEQ))
		else $error("previous string length out of range");
	// An error result is always a single, final transfer.
	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_bad_q) |-> (out_last_q && out_byte_q == '0))
		else $error("error result is not a lone final transfer");

endmodule

/* rtl/core/lzw_decoder_top.sv */
// Top level of the LZW decoder: ties the controller to the datapath.
// Depends on lzw_pkg, lzw_if, lzw_ctrl and lzw_datapath.
//
// Usage: codes enter on code_chan (code, stream_start) and decoded bytes
// leave on byte_chan (out_byte, last, bad_code), both valid/ready; a
// transfer happens when valid and ready are high at a rising clock edge.
// Set stream_start on the first code of a stream to clear the dictionary.
// Each code yields its string, first byte first, with last on the final
// byte; a code that is neither defined nor the next free code after an
// earlier code (with room left) yields one transfer with bad_code.
// One code is in work at a time. A code is decided, its chain walked
// one dictionary link at a time (the single read port of the dictionary
// memory sets this), the dictionary updated, then the first byte emitted
// and each further byte read and written through the reverse buffer.
// The next code is taken once the last byte sits in the output register.
// Reset clears the dictionary pointer and history and empties the output
// register; no clearing pass is needed. When the receiver holds ready low,
// the output register keeps its byte and decoding waits for it.
module lzw_decoder_top
	import lzw_pkg::*;
#(
	parameter int DICT_SIZE = 4096,
	parameter int MAX_SEQ   = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	lzw_code_if.sink   code_chan,
	lzw_byte_if.source byte_chan
);

	lzw_cmd_t    cmd;
	lzw_status_t status;
	logic        in_ready;

	// Sequencing.
	lzw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (code_chan.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Dictionary, buffers and output register.
	lzw_datapath #(
		.DICT_SIZE (DICT_SIZE),
		.MAX_SEQ   (MAX_SEQ)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_code   (code_chan.code),
		.in_start  (code_chan.stream_start),
		.out_ready (byte_chan.ready),
		.out_valid (byte_chan.valid),
		.out_byte  (byte_chan.out_byte),
		.out_last  (byte_chan.last),
		.out_bad   (byte_chan.bad_code)
	);

	assign code_chan.ready = in_ready;

endmodule
